// File: sv/compacting_key_value_table_defines.svh
// Assertion macros for the compacting key/value table.
// Included by the controller and datapath; no other dependencies.
`ifndef COMPACTING_KEY_VALUE_TABLE_DEFINES_SVH
`define COMPACTING_KEY_VALUE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Plain implication, checked at every clock edge outside reset
`define CKVT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ckvt assertion failed");
// Antecedent in this cycle, consequent in the next
`define CKVT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ckvt assertion failed");
`else
`define CKVT_ASSERT(name, clk, rst, prop)
`define CKVT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// File: sv/ckvt_pkg.sv
// Shared types and codes for the compacting key/value table.
// No dependencies; used by the controller, datapath and top level.
package ckvt_pkg;

   // Request kinds; code 3 is a no-op
   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_DELETE = 2'd2
   } req_kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2
   } rsp_status_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_SCAN  = 2'd1,
      S_SHIFT = 2'd2,
      S_DONE  = 2'd3
   } state_type;

   // Source of the result's read_value
   typedef enum logic [1:0] {
      SEL_ZERO  = 2'd0,
      SEL_FOUND = 2'd1,
      SEL_UNDEF = 2'd2
   } read_sel_type;

   // Entry count update applied when a result is written
   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } cnt_op_type;

   // Undefined value after reset (-9999)
   localparam logic [31:0] UNDEF_RESET = 32'hFFFF_D8F1;

   // Controller -> datapath commands
   typedef struct packed {
      logic           load;      // latch request, restart scan pointer
      logic           issue;     // read entry at pointer, advance pointer
      logic           seek;      // record hit, pointer to entry after it
      logic           shift_wr;  // write read entry one place down
      logic           finish;    // write result register, apply count op
      cnt_op_type     cnt_op;
      rsp_status_type res_status;
      read_sel_type   res_sel;
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic         hit;     // read data valid and key matches
      logic         rd_vld;  // a read is in flight this cycle
      logic         more;    // pointer below entry count
      logic         full;    // table holds CAPACITY entries
      logic         found;   // scan found the key
      req_kind_type kind;    // latched request kind
   } sts_type;

endpackage

// File: sv/ckvt_channels.sv
// Handshake channel interfaces for the compacting key/value table:
// request, response and configuration words. No dependencies.
interface ckvt_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  req_type;
   logic signed [31:0] req_key;
   logic signed [31:0] req_value;

   modport source (output valid, output req_type, output req_key, output req_value,
                   input ready);
   modport sink   (input valid, input req_type, input req_key, input req_value,
                   output ready);
endinterface

interface ckvt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] read_value;
   logic        [1:0]  status;
   logic        [6:0]  entry_count_out;
   logic               is_empty;
   logic               is_full;

   modport source (output valid, output read_value, output status,
                   output entry_count_out, output is_empty, output is_full,
                   input ready);
   modport sink   (input valid, input read_value, input status,
                   input entry_count_out, input is_empty, input is_full,
                   output ready);
endinterface

interface ckvt_csr_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] undefined_value;

   modport source (output valid, output undefined_value, input ready);
   modport sink   (input valid, input undefined_value, output ready);
endinterface

// File: sv/ckvt_datapath.sv
// Datapath of the compacting key/value table: entry memory, scan pointer,
// entry count, undefined-value register and result register. Uses ckvt_pkg.
`include "compacting_key_value_table_defines.svh"

module ckvt_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ckvt_pkg::cmd_type     cmd,
   output ckvt_pkg::sts_type     sts,
   input  logic                  in_valid_cfg,
   input  logic signed [31:0]    in_undef,
   input  logic [1:0]            in_type,
   input  logic signed [31:0]    in_key,
   input  logic signed [31:0]    in_value,
   output logic signed [31:0]    out_read_value,
   output logic [1:0]            out_status,
   output logic [6:0]            out_count,
   output logic                  out_empty,
   output logic                  out_full
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // entry memory, {key, value} per word
   logic [63:0] mem [CAPACITY];

   logic [31:0]            undef_ff, undef_in;
   ckvt_pkg::req_kind_type kind_ff;
   logic [31:0]            key_ff, val_ff;
   logic [CNT_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [63:0]            rd_data_ff;
   logic [CNT_W-1:0]       rd_idx_ff;
   logic                   rd_vld_ff;
   logic                   found_ff, found_in;
   logic [31:0]            found_val_ff;
   logic [31:0]            res_val_in;

   logic                   wr_en;
   logic [CNT_W-1:0]       wr_pos;
   logic [63:0]            wr_data;

   // status toward the controller
   assign sts.hit    = rd_vld_ff && (rd_data_ff[63:32] == key_ff);
   assign sts.rd_vld = rd_vld_ff;
   assign sts.more   = ptr_ff < count_ff;
   assign sts.full   = count_ff >= CNT_W'(CAPACITY);
   assign sts.found  = found_ff;
   assign sts.kind   = kind_ff;

   // single write port: insert at the tail or shift one place down
   assign wr_en   = cmd.shift_wr || (cmd.finish && cmd.cnt_op == ckvt_pkg::CNT_INC);
   assign wr_pos  = cmd.shift_wr ? rd_idx_ff - CNT_W'(1) : count_ff;
   assign wr_data = cmd.shift_wr ? rd_data_ff : {key_ff, val_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_pos[IDX_W-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[ptr_ff[IDX_W-1:0]];
      rd_idx_ff  <= ptr_ff;
   end

   // next-state logic for pointer, count, hit flag, config and result value
   always_comb begin
      undef_in = in_valid_cfg ? in_undef : undef_ff;

      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = '0;
      end else if (cmd.seek) begin
         ptr_in = rd_idx_ff + CNT_W'(1);
      end else if (cmd.issue) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end

      found_in = found_ff;
      if (cmd.load) begin
         found_in = 1'b0;
      end else if (cmd.seek) begin
         found_in = 1'b1;
      end

      count_in = count_ff;
      if (cmd.finish) begin
         case (cmd.cnt_op)
            ckvt_pkg::CNT_INC: count_in = count_ff + CNT_W'(1);
            ckvt_pkg::CNT_DEC: count_in = count_ff - CNT_W'(1);
            default:           count_in = count_ff;
         endcase
      end

      case (cmd.res_sel)
         ckvt_pkg::SEL_FOUND: res_val_in = found_val_ff;
         ckvt_pkg::SEL_UNDEF: res_val_in = undef_ff;
         default:             res_val_in = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         undef_ff  <= ckvt_pkg::UNDEF_RESET;
         ptr_ff    <= '0;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         undef_ff  <= undef_in;
         ptr_ff    <= ptr_in;
         count_ff  <= count_in;
         rd_vld_ff <= cmd.issue;
         found_ff  <= found_in;
      end
   end

   // request latch, hit value and result word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= ckvt_pkg::req_kind_type'(in_type);
         key_ff  <= in_key;
         val_ff  <= in_value;
      end
      if (cmd.seek) begin
         found_val_ff <= rd_data_ff[31:0];
      end
      if (cmd.finish) begin
         out_read_value <= res_val_in;
         out_status     <= cmd.res_status;
         out_count      <= 7'(count_in);
         out_empty      <= (count_in == '0);
         out_full       <= (count_in >= CNT_W'(CAPACITY));
      end
   end

   `CKVT_ASSERT(a_issue_in_table, clock, reset, cmd.issue |-> (ptr_ff < count_ff))
   `CKVT_ASSERT(a_insert_room, clock, reset, (cmd.finish && cmd.cnt_op == ckvt_pkg::CNT_INC) |-> (count_ff < CNT_W'(CAPACITY) && !found_ff))
   `CKVT_ASSERT(a_delete_found, clock, reset, (cmd.finish && cmd.cnt_op == ckvt_pkg::CNT_DEC) |-> (found_ff && count_ff != '0))

endmodule

// File: sv/ckvt_ctrl.sv
// Controller of the compacting key/value table: request sequencing state
// machine and response valid register. Uses ckvt_pkg.
`include "compacting_key_value_table_defines.svh"

module ckvt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ckvt_pkg::sts_type   sts,
   output ckvt_pkg::cmd_type   cmd
);

   ckvt_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // state register and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ckvt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.cnt_op     = ckvt_pkg::CNT_HOLD;
      cmd.res_status = ckvt_pkg::ST_ABSENT;
      cmd.res_sel    = ckvt_pkg::SEL_ZERO;

      case (state_ff)
         ckvt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ckvt_pkg::S_SCAN;
            end
         end

         // one entry read per cycle, compared in the cycle after the read
         ckvt_pkg::S_SCAN: begin
            if (sts.hit) begin
               cmd.seek = 1'b1;
               state_in = (sts.kind == ckvt_pkg::REQ_DELETE) ? ckvt_pkg::S_SHIFT
                                                             : ckvt_pkg::S_DONE;
            end else if (!sts.rd_vld && !sts.more) begin
               state_in = ckvt_pkg::S_DONE;
            end else if (sts.more) begin
               cmd.issue = 1'b1;
            end
         end

         // move later entries down by one place
         ckvt_pkg::S_SHIFT: begin
            cmd.shift_wr = sts.rd_vld;
            cmd.issue    = sts.more;
            if (!sts.rd_vld && !sts.more) begin
               state_in = ckvt_pkg::S_DONE;
            end
         end

         ckvt_pkg::S_DONE: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ckvt_pkg::S_IDLE;
               case (sts.kind)
                  ckvt_pkg::REQ_LOOKUP: begin
                     cmd.res_sel    = sts.found ? ckvt_pkg::SEL_FOUND : ckvt_pkg::SEL_UNDEF;
                     cmd.res_status = sts.found ? ckvt_pkg::ST_DONE : ckvt_pkg::ST_ABSENT;
                  end
                  ckvt_pkg::REQ_INSERT: begin
                     if (sts.found) begin
                        cmd.res_status = ckvt_pkg::ST_ABSENT;
                     end else if (sts.full) begin
                        cmd.res_status = ckvt_pkg::ST_FULL;
                     end else begin
                        cmd.res_status = ckvt_pkg::ST_DONE;
                        cmd.cnt_op     = ckvt_pkg::CNT_INC;
                     end
                  end
                  ckvt_pkg::REQ_DELETE: begin
                     if (sts.found) begin
                        cmd.res_status = ckvt_pkg::ST_DONE;
                        cmd.cnt_op     = ckvt_pkg::CNT_DEC;
                     end
                  end
                  default: begin
                     cmd.res_status = ckvt_pkg::ST_ABSENT;
                  end
               endcase
            end
         end

         default: state_in = ckvt_pkg::S_IDLE;
      endcase

      // response register: set by a finished request, cleared when taken
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   `CKVT_ASSERT(a_finish_slot_free, clock, reset, cmd.finish |-> (!rsp_valid_ff || rsp_ready))
   `CKVT_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_valid && req_ready, state_ff == ckvt_pkg::S_SCAN)
   `CKVT_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ckvt_pkg::S_DONE))

endmodule

// File: sv/compacting_key_value_table.sv
// Top level of the compacting key/value table: controller plus datapath
// behind request, response and configuration channels. Uses ckvt_pkg.
//
// A table of up to CAPACITY key/value pairs packed at the front of one
// memory, with an entry count. Each request word is a lookup, insert or
// delete; each yields one response word with read value, status, count, empty and full.
// One request is worked on at a time. The memory delivers one registered
// entry per cycle and the key compare follows in the cycle after the read.
// A lookup or insert stops at the first matching entry, or scans all
// entries when none matches; a delete of a found entry then reads each
// later entry and writes it one place down.
// A new request is taken while the previous response still waits to be read.
// The undefined value is written through the configuration channel, which
// is always ready, and resets to -9999.
module compacting_key_value_table #(
   parameter int CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   ckvt_req_if.sink   req_ch,
   ckvt_rsp_if.source rsp_ch,
   ckvt_csr_if.sink   csr_ch
);

   ckvt_pkg::cmd_type cmd;
   ckvt_pkg::sts_type sts;
   logic              req_ready;
   logic              rsp_valid;

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign csr_ch.ready = 1'b1;

   ckvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ckvt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .in_valid_cfg   (csr_ch.valid),
      .in_undef       (csr_ch.undefined_value),
      .in_type        (req_ch.req_type),
      .in_key         (req_ch.req_key),
      .in_value       (req_ch.req_value),
      .out_read_value (rsp_ch.read_value),
      .out_status     (rsp_ch.status),
      .out_count      (rsp_ch.entry_count_out),
      .out_empty      (rsp_ch.is_empty),
      .out_full       (rsp_ch.is_full)
   );

endmodule
